>>> rtl/fdcf_pkg.sv
// Shared types and constants for the fractional delay comb filter.
// No dependencies; imported by fdcf_ctrl, fdcf_datapath and the top level.
package fdcf_pkg;

	localparam int FRAC_W   = 8;   // fractional bits of a tap delay
	localparam int DELAY_W  = 20;  // tap delay register width
	localparam int GAIN_W   = 16;  // widest gain register (Q1.15)
	localparam int FBG_W    = 15;  // feedback gain width
	localparam int GAIN_SH  = 15;  // gain products are Q1.15
	localparam int TAP_W    = 2;   // tap counter width (up to four taps)
	localparam int NTAP_MAX = 4;
	localparam int CIDX_W   = 8;   // config index width
	localparam int CDATA_W  = 32;  // config data width

	localparam logic [CIDX_W-1:0] CFG_MULTI   = 8'd0;
	localparam logic [CIDX_W-1:0] CFG_BYPASS  = 8'd1;
	localparam logic [CIDX_W-1:0] CFG_WET     = 8'd2;
	localparam logic [CIDX_W-1:0] CFG_FB      = 8'd3;
	localparam logic [CIDX_W-1:0] CFG_DELAY0  = 8'd4;
	localparam logic [CIDX_W-1:0] CFG_DELAY1  = 8'd5;
	localparam logic [CIDX_W-1:0] CFG_DELAY2  = 8'd6;
	localparam logic [CIDX_W-1:0] CFG_DELAY3  = 8'd7;

	localparam logic [GAIN_W-1:0]  RST_WET_GAIN = 16'd16422;
	localparam logic [FBG_W-1:0]   RST_FB_GAIN  = 15'd16422;
	localparam logic [DELAY_W-1:0] RST_DELAY    = 20'd33210;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_INTP,
		ST_ACC,
		ST_FB,
		ST_WET,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic                            multi;
		logic                            bypass;
		logic [GAIN_W-1:0]               wet_gain;
		logic [FBG_W-1:0]                fb_gain;
		logic [NTAP_MAX-1:0][DELAY_W-1:0] delay;
	} cfg_t;

	typedef struct packed {
		logic             clr_wr;   // write zero at write pointer, advance it
		logic             load_x;   // capture input sample, clear accumulator
		logic             rd_en;    // read delay line
		logic             rd_hi;    // read upper neighbor (i+1)
		logic             lat_a0;   // latch lower neighbor
		logic             interp;   // register interpolation product
		logic             acc_add;  // add finished tap into accumulator
		logic             mul_fb;   // accumulator times feedback gain
		logic             mul_wet;  // saturate feedback sum, accumulator times wet gain
		logic             commit;   // write line, load output register
		logic [TAP_W-1:0] tap;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/fdcf_ctrl.sv
// Sequencer for the comb filter: clear pass, per-tap reads, gain steps, commit.
// Depends on fdcf_pkg; drives fdcf_datapath through cmd_t, reads sts_t.
module fdcf_ctrl #(
	parameter int NUM_TAPS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	input  logic           multi,
	input  logic           bypass,
	input  fdcf_pkg::sts_t sts,
	output logic           s_ready,
	output fdcf_pkg::cmd_t cmd
);
	import fdcf_pkg::*;

	state_t           state_q, state_d;
	logic [TAP_W-1:0] tap_q, tap_d;
	logic [TAP_W-1:0] last_tap;

	assign last_tap = multi ? TAP_W'(NUM_TAPS - 1) : '0;
	assign s_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
		end
	end

	always_comb begin
		state_d = state_q;
		tap_d   = tap_q;
		cmd     = '0;
		cmd.tap = tap_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				tap_d = '0;
				if (s_valid) begin
					cmd.load_x = 1'b1;
					// multi-mode bypass skips every tap: accumulator stays zero
					state_d = (multi && bypass) ? ST_FB : ST_RD0;
				end
			end
			ST_RD0: begin
				cmd.rd_en   = 1'b1;
				cmd.acc_add = (tap_q != '0);
				state_d     = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_hi  = 1'b1;
				cmd.lat_a0 = 1'b1;
				state_d    = ST_INTP;
			end
			ST_INTP: begin
				cmd.interp = 1'b1;
				if (tap_q == last_tap) begin
					state_d = ST_ACC;
				end else begin
					tap_d   = tap_q + 1'b1;
					state_d = ST_RD0;
				end
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_FB;
			end
			ST_FB: begin
				cmd.mul_fb = 1'b1;
				state_d    = ST_WET;
			end
			ST_WET: begin
				cmd.mul_wet = 1'b1;
				state_d     = ST_WRITE;
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && s_valid) |=> (state_q == ST_RD0 || state_q == ST_FB))
		else $error("accepted sample did not start tap or gain sequence");

	a_tap_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INTP && tap_q != last_tap) |=> (state_q == ST_RD0 && tap_q != '0))
		else $error("tap loop did not advance");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while output register still full");

endmodule

>>> rtl/fdcf_datapath.sv
// Delay line memory, interpolation, accumulator, gain multiplier, output register.
// Depends on fdcf_pkg; sequenced by fdcf_ctrl.
module fdcf_datapath #(
	parameter int DELAY_DEPTH  = 4096,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fdcf_pkg::cmd_t          cmd,
	input  fdcf_pkg::cfg_t          cfg,
	input  logic [SAMPLE_WIDTH-1:0] x_in,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [SAMPLE_WIDTH-1:0] out_data,
	output fdcf_pkg::sts_t          sts
);
	import fdcf_pkg::*;

	localparam int SW   = SAMPLE_WIDTH;
	localparam int AW   = $clog2(DELAY_DEPTH);
	localparam int PW   = AW + FRAC_W;          // position width, samples.frac
	localparam int DW   = SW + 1;               // neighbor difference
	localparam int PRW  = DW + FRAC_W + 1;      // interpolation product
	localparam int ACW  = SW + 2;               // sum of up to four taps
	localparam int MW   = ACW + GAIN_W + 1;     // gain product
	localparam int SUMW = ACW + 2;              // sample plus scaled taps

	logic [SW-1:0]         mem [DELAY_DEPTH];
	logic [SW-1:0]         rdata_q;
	logic [AW-1:0]         wp_q;
	logic [PW-1:0]         pos;
	logic [AW-1:0]         i0, raddr;
	logic [FRAC_W-1:0]     frac;
	logic                  we;
	logic [SW-1:0]         wdata;

	logic signed [SW-1:0]  x_q;
	logic signed [SW-1:0]  a0_q;
	logic signed [DW-1:0]  diff;
	logic signed [PRW-1:0] prod_s1;
	logic signed [ACW-1:0] acc_q;
	logic signed [MW-1:0]  mul_q;
	logic signed [MW-1:0]  mul_d;
	logic signed [SUMW-1:0] sum;
	logic [SW-1:0]         sum_sat;
	logic [SW-1:0]         wr_q;
	logic                  out_valid_q;
	logic [SW-1:0]         out_data_q;

	// read position = write pointer minus delay, modulo line length
	assign pos   = {wp_q, {FRAC_W{1'b0}}} - PW'(cfg.delay[cmd.tap]);
	assign i0    = pos[PW-1:FRAC_W];
	assign frac  = pos[FRAC_W-1:0];
	assign raddr = cmd.rd_hi ? i0 + 1'b1 : i0;

	assign we    = cmd.clr_wr | cmd.commit;
	assign wdata = cmd.clr_wr ? '0 : wr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wp_q] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// upper neighbor is in rdata_q during the interpolation step
	assign diff = DW'($signed(rdata_q)) - DW'(a0_q);

	assign mul_d = cmd.mul_fb
		? MW'(acc_q) * MW'($signed({2'b00, cfg.fb_gain}))
		: MW'(acc_q) * MW'($signed({1'b0, cfg.wet_gain}));

	// sample plus floored gain product, then clamp to sample range
	always_comb begin
		sum = SUMW'(x_q) + SUMW'(mul_q >>> GAIN_SH);
		if ((&sum[SUMW-1:SW-1]) || !(|sum[SUMW-1:SW-1])) begin
			sum_sat = sum[SW-1:0];
		end else if (sum[SUMW-1]) begin
			sum_sat = {1'b1, {(SW-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(SW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= $signed(x_in);
		end
		if (cmd.lat_a0) begin
			a0_q <= $signed(rdata_q);
		end
		if (cmd.interp) begin
			prod_s1 <= PRW'(diff) * PRW'($signed({1'b0, frac}));
		end
		if (cmd.load_x) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACW'(a0_q) + ACW'(prod_s1 >>> FRAC_W);
		end
		if (cmd.mul_fb || cmd.mul_wet) begin
			mul_q <= mul_d;
		end
		if (cmd.mul_wet) begin
			wr_q <= sum_sat;
		end
		if (cmd.commit) begin
			out_data_q <= cfg.bypass ? x_q : sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (we) begin
				wp_q <= wp_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign sts.clr_done = &wp_q;
	assign sts.out_free = !out_valid_q || out_ready;

	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (wp_q == AW'($past(wp_q) + 1'b1)))
		else $error("write pointer did not advance on commit");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !out_valid_q)
		else $error("output valid during clearing pass");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("output beat changed while stalled");

endmodule

>>> rtl/fractional_delay_comb_filter.sv
// Top level of the fractional delay comb filter: ports, config registers, wiring.
// Depends on fdcf_pkg, fdcf_ctrl and fdcf_datapath.
//
// Usage:
//  - s_* stream carries input samples (signed, SAMPLE_WIDTH bits, low bits of
//    s_tdata); m_* stream returns one filtered sample per input beat.
//  - cfg_* channel writes one register per beat: 0 multi_comb_mode,
//    1 wet_bypass, 2 wet_gain, 3 feedback_gain, 4..7 delay_tap_0..3.
//    Indexes above 7 are dropped. Write only while the filter is idle.
//  - One sample at a time: single mode runs tap 0, multi mode runs NUM_TAPS
//    taps, multi mode with bypass skips the taps. Each tap takes two neighbor
//    reads from the delay line memory plus the interpolation multiply; then
//    the feedback and wet gain steps share one multiplier before the commit.
//  - s_tready rises once the previous result sits in the output register,
//    so input is taken while that result waits on m_tready.
//  - Reset: config returns to defaults and a clearing pass zeros the delay
//    line, one entry per cycle, every entry once; s_tready stays low until
//    the pass is done. Config beats are taken throughout.
//  - A stalled receiver holds m_tvalid/m_tdata; the next sample finishes its
//    work and waits until the output register frees up.
//  - DELAY_DEPTH must be a power of two.
module fractional_delay_comb_filter #(
	parameter int DELAY_DEPTH  = 4096,
	parameter int NUM_TAPS     = 4,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // [SW-1:0] sample_in
	// output stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,   // [SW-1:0] sample_out
	// register write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fdcf_pkg::CIDX_W-1:0]           cfg_index,
	input  logic [fdcf_pkg::CDATA_W-1:0]          cfg_data
);
	import fdcf_pkg::*;

	localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

	cfg_t                    cfg_q;
	cmd_t                    cmd;
	sts_t                    sts;
	logic [SAMPLE_WIDTH-1:0] out_data;

	// registers take a beat every cycle; values masked to their widths
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.multi    <= 1'b0;
			cfg_q.bypass   <= 1'b0;
			cfg_q.wet_gain <= RST_WET_GAIN;
			cfg_q.fb_gain  <= RST_FB_GAIN;
			cfg_q.delay    <= {NTAP_MAX{RST_DELAY}};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MULTI:  cfg_q.multi    <= cfg_data[0];
				CFG_BYPASS: cfg_q.bypass   <= cfg_data[0];
				CFG_WET:    cfg_q.wet_gain <= cfg_data[GAIN_W-1:0];
				CFG_FB:     cfg_q.fb_gain  <= cfg_data[FBG_W-1:0];
				CFG_DELAY0: cfg_q.delay[0] <= cfg_data[DELAY_W-1:0];
				CFG_DELAY1: cfg_q.delay[1] <= cfg_data[DELAY_W-1:0];
				CFG_DELAY2: cfg_q.delay[2] <= cfg_data[DELAY_W-1:0];
				CFG_DELAY3: cfg_q.delay[3] <= cfg_data[DELAY_W-1:0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	fdcf_ctrl #(
		.NUM_TAPS (NUM_TAPS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.multi   (cfg_q.multi),
		.bypass  (cfg_q.bypass),
		.sts     (sts),
		.s_ready (s_tready),
		.cmd     (cmd)
	);

	fdcf_datapath #(
		.DELAY_DEPTH  (DELAY_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.x_in      (s_tdata[SAMPLE_WIDTH-1:0]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_data),
		.sts       (sts)
	);

	// pad sample to whole bytes with zeros
	assign m_tdata = TDW'(out_data);

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for fractional_delay_comb_filter: streams samples, writes registers
// between phases and predicts every output beat in a small scoreboard class.
// Depends on fdcf_pkg and the filter RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fdcf_pkg::*;

	localparam int DEPTH   = 4096;
	localparam int NTAPS   = 4;
	localparam int SW      = 24;
	localparam int TDATA_W = ((SW + 7) / 8) * 8;
	localparam longint SPAN = longint'(DEPTH) * 256;   // line length in 1/256 sample
	localparam longint SMAX = (longint'(1) << (SW - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;

	localparam int RANDOM_ITEMS   = 1200;
	localparam int LIMIT_CYCLES   = 1_000_000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES    = 4 + 3 * NTAPS + 1 + 8;   // slowest path plus margin

	// index past the register map, must be dropped by the block
	localparam logic [CIDX_W-1:0] CFG_SPARE_TOP = 8'hFF;

	localparam logic [DELAY_W-1:0] DLY_SUB_HALF   = 20'd128;      // half a sample
	localparam logic [DELAY_W-1:0] DLY_ONE        = 20'd256;
	localparam logic [DELAY_W-1:0] DLY_TWO_HALF   = 20'd640;
	localparam logic [DELAY_W-1:0] DLY_TOP_RANGE  = 20'd1048064;
	localparam logic [DELAY_W-1:0] DLY_ALL_ONES   = 20'hFFFFF;
	localparam logic [GAIN_W-1:0]  GAIN_UNITY     = 16'd32768;
	localparam logic [GAIN_W-1:0]  GAIN_ALL_ONES  = 16'hFFFF;
	localparam logic [FBG_W-1:0]   FB_TOP_RANGE   = 15'd32580;
	localparam logic [FBG_W-1:0]   FB_ALL_ONES    = 15'h7FFF;
	localparam logic [SW-1:0]      S_MAX          = 24'h7FFFFF;
	localparam logic [SW-1:0]      S_MIN          = 24'h800000;

	typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_style_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;    // [23:0] sample_in
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;    // [23:0] sample_out
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CDATA_W-1:0] cfg_data;

	// Scoreboard: own copy of the delay line and registers. Each accepted
	// input beat is run through the comb here; output beats pop in order.
	class comb_scoreboard;
		logic signed [SW-1:0] line_mem [DEPTH];
		int                   wr_pos;
		logic                 multi;
		logic                 bypass;
		logic [GAIN_W-1:0]    wet_gain;
		logic [FBG_W-1:0]     fb_gain;
		logic [DELAY_W-1:0]   tap_delay [NTAP_MAX];
		logic [SW-1:0]        pending_out [$];
		int                   errors;
		int                   n_in;
		int                   n_out;

		function new();
			foreach (line_mem[i])
				line_mem[i] = '0;
			foreach (tap_delay[i])
				tap_delay[i] = RST_DELAY;
			wr_pos   = 0;
			multi    = 1'b0;
			bypass   = 1'b0;
			wet_gain = RST_WET_GAIN;
			fb_gain  = RST_FB_GAIN;
			errors   = 0;
			n_in     = 0;
			n_out    = 0;
		endfunction

		function void set_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
			case (idx)
				CFG_MULTI:  multi    = val[0];
				CFG_BYPASS: bypass   = val[0];
				CFG_WET:    wet_gain = val[GAIN_W-1:0];
				CFG_FB:     fb_gain  = val[FBG_W-1:0];
				CFG_DELAY0, CFG_DELAY1, CFG_DELAY2, CFG_DELAY3:
					tap_delay[idx - CFG_DELAY0] = val[DELAY_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v);
			if (v > SMAX)
				return SMAX;
			if (v < SMIN)
				return SMIN;
			return v;
		endfunction

		// linear interpolation between neighbors, read position wraps the line
		function longint read_tap(logic [DELAY_W-1:0] d);
			longint pos, fr, a0, a1;
			int     i0, i1;
			pos = (longint'(wr_pos) * 256 + SPAN - (longint'(d) % SPAN)) % SPAN;
			i0  = int'(pos >> 8);
			i1  = (i0 + 1 >= DEPTH) ? 0 : i0 + 1;
			fr  = pos & 255;
			a0  = line_mem[i0];
			a1  = line_mem[i1];
			return a0 + (((a1 - a0) * fr) >>> 8);
		endfunction

		function void take_sample(logic [SW-1:0] raw);
			longint x, s, wr, y;
			x = longint'($signed(raw));
			if (!multi) begin
				s  = read_tap(tap_delay[0]);
				wr = clip(x + ((s * longint'(fb_gain)) >>> GAIN_SH));
				y  = bypass ? x : clip(x + ((s * longint'(wet_gain)) >>> GAIN_SH));
			end else if (bypass) begin
				wr = x;
				y  = x;
			end else begin
				s = 0;
				for (int n = 0; n < NTAPS; n++)
					s += read_tap(tap_delay[n]);
				wr = clip(x + ((s * longint'(fb_gain)) >>> GAIN_SH));
				y  = clip(x + ((s * longint'(wet_gain)) >>> GAIN_SH));
			end
			line_mem[wr_pos] = wr[SW-1:0];
			wr_pos = (wr_pos + 1) % DEPTH;
			pending_out.push_back(y[SW-1:0]);
			n_in++;
		endfunction

		function void check_output(logic [SW-1:0] got);
			logic [SW-1:0] want;
			n_out++;
			if (pending_out.size() == 0) begin
				$error("sample_out: no result expected, actual %0d", $signed(got));
				errors++;
				return;
			end
			want = pending_out.pop_front();
			if (got !== want) begin
				$error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
				errors++;
			end
		endfunction
	endclass

	comb_scoreboard sb;

	logic [SW-1:0] tx_queue [$];   // samples waiting for the sender
	int            tx_gap_max;
	int            tx_burst_max;
	rx_style_t     rx_style;
	logic          rx_hold_req;
	int            items_total;
	int            cycle_count;

	fractional_delay_comb_filter #(
		.DELAY_DEPTH (DEPTH),
		.NUM_TAPS    (NTAPS),
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Watchdog: covers the clearing pass, hold-offs and the slowest stall mix many times over.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL fractional_delay_comb_filter");
			$finish;
		end
	end

	// Beat monitor. Values read at the edge are the ones from before it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_sample(s_tdata[SW-1:0]);
			if (m_tvalid && m_tready)
				sb.check_output(m_tdata[SW-1:0]);
		end
	end

	// Sender: bursts of random length, random gaps between them.
	// Valid stays high across beats inside a burst.
	initial begin : sender
		int burst, gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (tx_queue.size() == 0) begin
				@(posedge clk);
			end else begin
				burst = $urandom_range(1, tx_burst_max);
				while (burst > 0 && tx_queue.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= TDATA_W'(tx_queue[0]);
					@(posedge clk);
					while (!s_tready)
						@(posedge clk);
					void'(tx_queue.pop_front());
					burst--;
				end
				gap = $urandom_range(0, tx_gap_max);
				if (gap > 0 || tx_queue.size() == 0)
					s_tvalid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
	end

	// Receiver: per-phase stall pattern, plus a long hold-off on request
	// counted here so the block backs up into its input.
	initial begin : receiver
		int   hold_left, beat_phase;
		logic rdy;
		hold_left  = 0;
		beat_phase = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = RX_HOLD_CYCLES;
			end
			beat_phase = (beat_phase + 1) % 7;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_style)
					RX_OPEN:     rdy = 1'b1;
					RX_COIN:     rdy = 1'($urandom_range(0, 1));
					RX_PERIODIC: rdy = (beat_phase < 4);
					default:     rdy = ($urandom_range(0, 5) == 0);
				endcase
			end
			m_tready <= rdy;
		end
	end

	// One register beat; valid stays high so back-to-back writes need no re-raise.
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic queue_sample(input logic [SW-1:0] v);
		tx_queue.push_back(v);
		items_total++;
	endtask

	// Block is idle once every beat sent has come back.
	task automatic wait_results();
		while (sb.n_out < items_total)
			@(posedge clk);
	endtask

	// Sometimes set bits above the register width; the block must mask them.
	function automatic logic [CDATA_W-1:0] dirty(logic [CDATA_W-1:0] v, int w);
		if ($urandom_range(0, 3) == 0)
			return v | ($urandom << w);
		return v;
	endfunction

	// Mostly delays that land on samples already written, some sub-sample,
	// some wrapping far behind into the untouched part of the line.
	function automatic logic [DELAY_W-1:0] pick_delay(int filled);
		int top;
		top = ((filled < DEPTH - 1) ? filled : DEPTH - 1) * 256 + 255;
		if (top < 256)
			top = 256;
		case ($urandom_range(0, 7))
			0: return DELAY_W'($urandom_range(0, 255));
			1: return DELAY_W'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return DLY_ONE;
					2: return DLY_TOP_RANGE;
					default: return DLY_ALL_ONES;
				endcase
			end
			3, 4: return DELAY_W'($urandom_range(0, 32 * 256));
			default: return DELAY_W'($urandom_range(256, top));
		endcase
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return SW'($urandom_range(0, 4095) - 2048);
			1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
			2: return SW'($urandom_range(0, 65535) - 32768);
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic pick_settings(output logic was_multi, output logic was_bypass);
		logic [GAIN_W-1:0] wet;
		logic [FBG_W-1:0]  fbk;
		case ($urandom_range(0, 5))
			0: wet = '0;
			1: wet = GAIN_UNITY;
			2: wet = GAIN_ALL_ONES;
			3: wet = GAIN_W'($urandom);
			default: wet = GAIN_W'($urandom_range(0, GAIN_UNITY));
		endcase
		case ($urandom_range(0, 5))
			0: fbk = '0;
			1: fbk = FB_TOP_RANGE;
			2: fbk = FB_ALL_ONES;
			default: fbk = FBG_W'($urandom_range(0, FB_ALL_ONES));
		endcase
		write_reg(CFG_MULTI, dirty(CDATA_W'($urandom_range(0, 1)), 1));
		write_reg(CFG_BYPASS, dirty(CDATA_W'($urandom_range(0, 3) == 0), 1));
		write_reg(CFG_WET, dirty(CDATA_W'(wet), GAIN_W));
		write_reg(CFG_FB, dirty(CDATA_W'(fbk), FBG_W));
		write_reg(CFG_DELAY0, dirty(CDATA_W'(pick_delay(sb.wr_pos)), DELAY_W));
		write_reg(CFG_DELAY1, dirty(CDATA_W'(pick_delay(sb.wr_pos)), DELAY_W));
		write_reg(CFG_DELAY2, dirty(CDATA_W'(pick_delay(sb.wr_pos)), DELAY_W));
		write_reg(CFG_DELAY3, dirty(CDATA_W'(pick_delay(sb.wr_pos)), DELAY_W));
		if ($urandom_range(0, 2) == 0)
			write_reg(CIDX_W'($urandom_range(CFG_DELAY3 + 1, CFG_SPARE_TOP)), $urandom);
		cfg_valid  <= 1'b0;
		was_multi  = sb.multi;
		was_bypass = sb.bypass;
	endtask

	initial begin : main
		int   phase, n, random_sent, n_settings, n_multi, n_bypass;
		logic m, b;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		rx_style     = RX_OPEN;
		rx_hold_req  = 1'b0;
		tx_gap_max   = 3;
		tx_burst_max = 8;
		items_total  = 0;
		cycle_count  = 0;
		random_sent  = 0;
		n_settings   = 0;
		n_multi      = 0;
		n_bypass     = 0;
		sb = new();

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, sample extremes; offered during the clearing pass.
		queue_sample(S_MAX);
		queue_sample(S_MIN);
		queue_sample('0);
		queue_sample({SW{1'b1}});
		queue_sample(SW'(1));
		queue_sample(24'h400000);
		wait_results();

		// Single comb, delay under one sample (halfway between the newest and oldest
		// entry), full gains so the write and the output saturate. Stray index first.
		rx_style = RX_COIN;
		write_reg(CFG_SPARE_TOP, '1);
		write_reg(CFG_DELAY0, CDATA_W'(DLY_SUB_HALF));
		write_reg(CFG_WET, CDATA_W'(GAIN_UNITY));
		write_reg(CFG_FB, CDATA_W'(FB_TOP_RANGE));
		cfg_valid <= 1'b0;
		queue_sample(S_MAX);
		queue_sample(S_MAX);
		queue_sample(S_MAX);
		queue_sample(S_MIN);
		queue_sample(S_MIN);
		wait_results();

		// Single comb with wet bypass: dry out, feedback still writes the line.
		write_reg(CFG_BYPASS, CDATA_W'(1));
		write_reg(CFG_DELAY0, CDATA_W'(DLY_ONE));
		cfg_valid <= 1'b0;
		queue_sample(24'h123456);
		queue_sample(S_MIN);
		queue_sample(24'h000100);
		queue_sample(S_MAX);
		wait_results();

		// Multi-tap: one, two and a half, max field (wraps the line) and zero delay.
		write_reg(CFG_BYPASS, '0);
		write_reg(CFG_MULTI, CDATA_W'(1));
		write_reg(CFG_DELAY1, CDATA_W'(DLY_TWO_HALF));
		write_reg(CFG_DELAY2, CDATA_W'(DLY_ALL_ONES));
		write_reg(CFG_DELAY3, '0);
		cfg_valid <= 1'b0;
		queue_sample(24'h200000);
		queue_sample(24'hE00000);
		queue_sample(S_MAX);
		queue_sample(24'h000007);
		queue_sample(S_MIN);
		wait_results();

		// Multi-tap bypass: taps skipped, input written and passed as is.
		write_reg(CFG_BYPASS, CDATA_W'(1));
		cfg_valid <= 1'b0;
		queue_sample(24'h654321);
		queue_sample(S_MIN);
		queue_sample(24'hFFFFFE);
		wait_results();

		// Random phases: new settings and idle patterns each time, the
		// sender pausing at every boundary until the block drains.
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			pick_settings(m, b);
			n_settings++;
			n_multi  += m;
			n_bypass += b;
			rx_style     = rx_style_t'($urandom_range(RX_OPEN, RX_SPARSE));
			tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			tx_burst_max = $urandom_range(1, 30);
			n = $urandom_range(60, 140);
			if (phase == 2 || phase == 7) begin
				// receiver holds off while samples keep coming
				rx_style   = RX_OPEN;
				tx_gap_max = 0;
				n          = 150;
			end
			for (int k = 0; k < n; k++)
				queue_sample(pick_sample());
			random_sent += n;
			if (phase == 2 || phase == 7)
				rx_hold_req = 1'b1;
			wait_results();
			phase++;
		end

		wait_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.pending_out.size() != 0) begin
			$error("sample_out: %0d expected results never arrived", sb.pending_out.size());
			sb.errors++;
		end

		$display("Covered %0d samples in, %0d results checked, %0d random settings",
			sb.n_in, sb.n_out, n_settings);
		$display("(%0d multi-tap, %0d bypass), sample and gain extremes, stalls and hold-offs",
			n_multi, n_bypass);
		if (sb.errors == 0)
			$display("PASS fractional_delay_comb_filter");
		else
			$display("FAIL fractional_delay_comb_filter");
		$finish;
	end

endmodule
